[design/vpsp_pkg.sv]
// Shared types, constants and rounding helper for the vertical plane slab projector.
package vpsp_pkg;

  localparam int COORD_W   = 32;
  localparam int HALF_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 8;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = Q_PTR_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [65:0]        wide_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_START_Z    = 3'd2,
    CFG_END_X      = 3'd3,
    CFG_END_Y      = 3'd4,
    CFG_END_Z      = 3'd5,
    CFG_SLAB_HALF  = 3'd6
  } cfg_idx_t;

  // Derived plane description
  typedef struct packed {
    coord_t            normal_a;
    coord_t            normal_b;
    coord_t            plane_offset;
    coord_t            span_low;
    coord_t            span_high;
    coord_t            height_limit;
    logic [HALF_W-1:0] half_width;
    logic              degenerate;
  } plane_t;

  // One request held between front and back
  typedef struct packed {
    wide_t  tsum;
    coord_t z;
  } q_item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               nonempty;
  } q_stat_t;

  // Q.46 to Q16.16: round half up, then saturate
  function automatic coord_t to_coord(input wide_t v);
    logic signed [66:0] t;
    logic signed [36:0] q;
    t = 67'(v) + 67'sd536870912;
    q = t[66:30];
    if (q > 37'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (q < -37'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return q[31:0];
    end
  endfunction

endpackage

[design/vpsp_derive.sv]
// Configuration registers and the sequencer that derives the plane from the endpoints.
module vpsp_derive (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vpsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpsp_pkg::COORD_W-1:0]      cfg_data,
  output vpsp_pkg::plane_t                  plane,
  output logic                              busy
);
  import vpsp_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_INIT = 10'b0000000010,
    ST_NORM = 10'b0000000100,
    ST_SQ   = 10'b0000001000,
    ST_SQRT = 10'b0000010000,
    ST_DSET = 10'b0000100000,
    ST_DIV  = 10'b0001000000,
    ST_MUL  = 10'b0010000000,
    ST_FIN  = 10'b0100000000,
    ST_SPAN = 10'b1000000000
  } state_t;

  state_t            state;
  coord_t            start_x, start_y, start_z, end_x, end_y, end_z;
  logic [32:0]       ua, ub;
  logic              na, nb;
  logic [4:0]        step;
  logic [63:0]       sq_n, sq_res;
  logic [31:0]       dv_rem, dv_lo, dv_q;
  logic              dv_sel;
  logic signed [32:0] mul_a, mul_b;
  wide_t             mul_p;
  wide_t             acc_o, acc_1, acc_2;
  coord_t            x1, x2;
  logic              restart;

  // Any endpoint write starts the derivation afresh
  assign restart = cfg_we && (cfg_index <= CFG_IDX_W'(CFG_END_Z));

  // Endpoint differences for the initial step
  logic signed [32:0] da, db;
  logic [32:0]        ua_init, ub_init, or_mask;
  assign da      = 33'(end_y) - 33'(start_y);
  assign db      = 33'(start_x) - 33'(end_x);
  assign ua_init = da[32] ? 33'(-da) : 33'(da);
  assign ub_init = db[32] ? 33'(-db) : 33'(db);
  assign or_mask = ua | ub;

  // Square-root step
  logic [63:0] sq_bit, sq_trial;
  assign sq_bit   = 64'd1 << {step, 1'b0};
  assign sq_trial = sq_res + sq_bit;

  // Restoring division step
  logic [31:0] len, dv_u, qn;
  logic [61:0] dv_num;
  logic [32:0] rem2, rem_sub;
  logic        dv_ge;
  assign len     = sq_res[31:0];
  assign dv_u    = dv_sel ? ub[31:0] : ua[31:0];
  assign dv_num  = {dv_u, 30'b0} + 62'(len >> 1);
  assign rem2    = {dv_rem, dv_lo[31]};
  assign dv_ge   = rem2 >= {1'b0, len};
  assign rem_sub = rem2 - {1'b0, len};
  assign qn      = {dv_q[30:0], dv_ge};

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_SQ) begin
      mul_a = (step == 5'd0) ? {1'b0, ua[31:0]} : {1'b0, ub[31:0]};
      mul_b = mul_a;
    end else if (state == ST_MUL) begin
      case (step)
        5'd0: begin mul_a = 33'(plane.normal_a); mul_b = 33'(start_x); end
        5'd1: begin mul_a = 33'(plane.normal_b); mul_b = 33'(start_y); end
        5'd2: begin mul_a = 33'(plane.normal_a); mul_b = 33'(start_y); end
        5'd3: begin mul_a = 33'(plane.normal_b); mul_b = 33'(start_x); end
        5'd4: begin mul_a = 33'(plane.normal_a); mul_b = 33'(end_y);   end
        5'd5: begin mul_a = 33'(plane.normal_b); mul_b = 33'(end_x);   end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      start_x            <= '0;
      start_y            <= '0;
      start_z            <= '0;
      end_x              <= '0;
      end_y              <= '0;
      end_z              <= '0;
      plane.normal_a     <= '0;
      plane.normal_b     <= '0;
      plane.plane_offset <= '0;
      plane.span_low     <= '0;
      plane.span_high    <= '0;
      plane.height_limit <= '0;
      plane.half_width   <= '0;
      plane.degenerate   <= 1'b1;
      step               <= '0;
      dv_sel             <= 1'b0;
    end else begin
      // Register writes are taken in any state
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_X:   start_x          <= cfg_data;
          CFG_START_Y:   start_y          <= cfg_data;
          CFG_START_Z:   start_z          <= cfg_data;
          CFG_END_X:     end_x            <= cfg_data;
          CFG_END_Y:     end_y            <= cfg_data;
          CFG_END_Z:     end_z            <= cfg_data;
          CFG_SLAB_HALF: plane.half_width <= cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        state <= ST_INIT;
      end else begin
        unique case (state)
          ST_IDLE: ;
          ST_INIT: begin
            plane.height_limit <= (start_z > end_z) ? start_z : end_z;
            na <= da[32];
            nb <= db[32];
            if (ua_init == '0 && ub_init == '0) begin
              plane.degenerate   <= 1'b1;
              plane.normal_a     <= '0;
              plane.normal_b     <= '0;
              plane.plane_offset <= '0;
              plane.span_low     <= '0;
              plane.span_high    <= '0;
              state              <= ST_IDLE;
            end else begin
              plane.degenerate <= 1'b0;
              if (ua_init[32] | ub_init[32] | ua_init[31] | ub_init[31]) begin
                ua <= ua_init >> 1;
                ub <= ub_init >> 1;
              end else begin
                ua <= ua_init;
                ub <= ub_init;
              end
              state <= ST_NORM;
            end
          end
          // Shift left one bit a cycle until the larger magnitude reaches 2^30
          ST_NORM: begin
            if (or_mask[32:30] == 3'b000) begin
              ua <= ua << 1;
              ub <= ub << 1;
            end else begin
              step  <= 5'd0;
              state <= ST_SQ;
            end
          end
          ST_SQ: begin
            if (step == 5'd0) begin
              step <= 5'd1;
            end else if (step == 5'd1) begin
              sq_n <= mul_p[63:0];
              step <= 5'd2;
            end else begin
              sq_n   <= sq_n + mul_p[63:0];
              sq_res <= '0;
              step   <= 5'd31;
              state  <= ST_SQRT;
            end
          end
          // One result bit a cycle
          ST_SQRT: begin
            if (sq_n >= sq_trial) begin
              sq_n   <= sq_n - sq_trial;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            if (step == 5'd0) begin
              dv_sel <= 1'b0;
              state  <= ST_DSET;
            end else begin
              step <= step - 5'd1;
            end
          end
          ST_DSET: begin
            dv_rem <= {2'b00, dv_num[61:32]};
            dv_lo  <= dv_num[31:0];
            dv_q   <= '0;
            step   <= 5'd0;
            state  <= ST_DIV;
          end
          // One quotient bit a cycle, first for a then for b
          ST_DIV: begin
            dv_rem <= dv_ge ? rem_sub[31:0] : rem2[31:0];
            dv_lo  <= dv_lo << 1;
            dv_q   <= qn;
            if (step == 5'd31) begin
              if (!dv_sel) begin
                plane.normal_a <= na ? -$signed(qn) : $signed(qn);
                dv_sel         <= 1'b1;
                state          <= ST_DSET;
              end else begin
                plane.normal_b <= nb ? -$signed(qn) : $signed(qn);
                step           <= 5'd0;
                state          <= ST_MUL;
              end
            end else begin
              step <= step + 5'd1;
            end
          end
          // Products for the offset and the endpoint abscissas
          ST_MUL: begin
            case (step)
              5'd1: acc_o <= mul_p;
              5'd2: acc_o <= acc_o + mul_p;
              5'd3: acc_1 <= mul_p;
              5'd4: acc_1 <= acc_1 - mul_p;
              5'd5: acc_2 <= mul_p;
              5'd6: acc_2 <= acc_2 - mul_p;
              default: ;
            endcase
            if (step == 5'd6) begin
              state <= ST_FIN;
            end else begin
              step <= step + 5'd1;
            end
          end
          ST_FIN: begin
            plane.plane_offset <= to_coord(-acc_o);
            x1                 <= to_coord(acc_1);
            x2                 <= to_coord(acc_2);
            state              <= ST_SPAN;
          end
          ST_SPAN: begin
            plane.span_low  <= (x1 < x2) ? x1 : x2;
            plane.span_high <= (x1 < x2) ? x2 : x1;
            state           <= ST_IDLE;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[design/vpsp_front.sv]
// Front pipeline: accepts points, forms the plane distance and drops points outside the slab.
module vpsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_ready,
  input  vpsp_pkg::coord_t      point_x,
  input  vpsp_pkg::coord_t      point_y,
  input  vpsp_pkg::coord_t      point_z,
  input  vpsp_pkg::plane_t      plane,
  input  logic                  busy,
  input  vpsp_pkg::q_stat_t     q_stat,
  output logic                  push,
  output vpsp_pkg::q_item_t     push_item
);
  import vpsp_pkg::*;

  logic               v1, v2, v3;
  coord_t             s1_x, s1_y, s1_z, s2_z, s3_z;
  logic signed [63:0] p_ax, p_by, p_ay, p_bx;
  wide_t              s3_s, s3_t;

  // Credit check: every point in flight has a queue slot waiting
  logic [Q_CNT_W:0] held;
  logic             take;
  assign held        = (Q_CNT_W+1)'(q_stat.count) + (Q_CNT_W+1)'(v1) +
                       (Q_CNT_W+1)'(v2) + (Q_CNT_W+1)'(v3);
  assign point_ready = !busy && (held < (Q_CNT_W+1)'(Q_DEPTH));
  assign take        = point_valid && point_ready;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Input capture, products, sums
  wide_t d_ext;
  assign d_ext = {{4{plane.plane_offset[31]}}, plane.plane_offset, 30'b0};

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x <= point_x;
      s1_y <= point_y;
      s1_z <= point_z;
    end
    p_ax <= s1_x * plane.normal_a;
    p_by <= s1_y * plane.normal_b;
    p_ay <= s1_y * plane.normal_a;
    p_bx <= s1_x * plane.normal_b;
    s2_z <= s1_z;
    s3_s <= 66'(p_ax) + 66'(p_by) + d_ext;
    s3_t <= 66'(p_ay) - 66'(p_bx);
    s3_z <= s2_z;
  end

  // Slab test
  logic [65:0] mag, bound;
  assign mag   = s3_s[65] ? 66'(-s3_s) : 66'(s3_s);
  assign bound = {5'b0, plane.half_width, 30'b0};

  assign push           = v3 && !plane.degenerate && (mag < bound);
  assign push_item.tsum = s3_t;
  assign push_item.z    = s3_z;

endmodule

[design/vpsp_queue.sv]
// Short request queue between the front and the back.
module vpsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vpsp_pkg::q_item_t  push_item,
  input  logic               pop,
  output vpsp_pkg::q_item_t  pop_item,
  output vpsp_pkg::q_stat_t  q_stat
);
  import vpsp_pkg::*;

  q_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  assign pop_item        = mem[rd_ptr];
  assign q_stat.count    = count;
  assign q_stat.nonempty = (count != '0);

endmodule

[design/vpsp_back.sv]
// Back pipeline: rounds the abscissa, applies the span and height window, holds the result.
module vpsp_back (
  input  logic               clk,
  input  logic               rst,
  input  vpsp_pkg::q_stat_t  q_stat,
  input  vpsp_pkg::q_item_t  pop_item,
  output logic               pop,
  input  vpsp_pkg::plane_t   plane,
  output logic               result_valid,
  input  logic               result_ready,
  output vpsp_pkg::coord_t   plane_abscissa,
  output vpsp_pkg::coord_t   plane_height
);
  import vpsp_pkg::*;

  logic   b1_v;
  coord_t b1_u, b1_z;

  // Window test on the rounded abscissa
  logic keep, out_free, b1_move, b1_free;
  assign keep     = (b1_u > plane.span_low) && (b1_u < plane.span_high) &&
                    (b1_z < plane.height_limit);
  assign out_free = !result_valid || result_ready;
  assign b1_move  = b1_v && (out_free || !keep);
  assign b1_free  = !b1_v || b1_move;
  assign pop      = q_stat.nonempty && b1_free;

  // Rounding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (b1_free) begin
      b1_v <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_u <= to_coord(pop_item.tsum);
      b1_z <= pop_item.z;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b1_move && keep) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move && keep) begin
      plane_abscissa <= b1_u;
      plane_height   <= b1_z;
    end
  end

endmodule

[design/vertical_plane_slab_project_top.sv]
// Top level of the vertical plane slab projector.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  point     | point_valid / point_ready | point_x, point_y, point_z
//  result    | result_valid/result_ready | plane_abscissa, plane_height
//  config    | cfg_we (no wait)          | cfg_index, cfg_data
//
// One point is accepted per cycle while point_ready is high; a kept point passes the input
// capture, product and sum registers, the queue, the rounding stage and the output
// register. Points outside the slab or window give no result. After the last write to
// an endpoint register the derivation sequencer runs (normalising shift, 32-step square
// root, two 32-step divisions, six products through one shared multiplier); point_ready
// is low while it runs. Another endpoint write during derivation starts it again.
// Reset is synchronous and leaves the plane degenerate, so every point is dropped.
// The front holds a queue slot for every point in flight, so result stalls back-pressure
// point_ready through the eight-entry queue.
module vertical_plane_slab_project_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            point_valid,
  output logic                            point_ready,
  input  vpsp_pkg::coord_t                point_x,
  input  vpsp_pkg::coord_t                point_y,
  input  vpsp_pkg::coord_t                point_z,
  output logic                            result_valid,
  input  logic                            result_ready,
  output vpsp_pkg::coord_t                plane_abscissa,
  output vpsp_pkg::coord_t                plane_height,
  input  logic                            cfg_we,
  input  logic [vpsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpsp_pkg::COORD_W-1:0]    cfg_data
);
  import vpsp_pkg::*;

  plane_t  plane;
  logic    busy;
  q_stat_t q_stat;
  logic    q_push, q_pop;
  q_item_t push_item, pop_item;

  vpsp_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plane     (plane),
    .busy      (busy)
  );

  vpsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .plane       (plane),
    .busy        (busy),
    .q_stat      (q_stat),
    .push        (q_push),
    .push_item   (push_item)
  );

  vpsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  vpsp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .pop_item       (pop_item),
    .pop            (q_pop),
    .plane          (plane),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .plane_abscissa (plane_abscissa),
    .plane_height   (plane_height)
  );

  // No points taken while the plane is being derived
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !point_ready)
    else $error("point accepted during plane derivation");

  // The credit scheme never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_stat.count != Q_CNT_W'(Q_DEPTH)))
    else $error("push into full queue");

  // A degenerate plane lets nothing through
  a_degenerate_drop: assert property (@(posedge clk) disable iff (rst)
    plane.degenerate |-> !q_push)
    else $error("point kept with degenerate plane");

  // An endpoint write starts a derivation
  a_write_derives: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && !busy && (cfg_index < CFG_IDX_W'(CFG_SLAB_HALF))) |=> busy)
    else $error("endpoint write did not start derivation");

endmodule
